@@ src/gmsb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gmsb_pkg
// Shared types, codes and constants of the grid breadth-first distance block.
// ----------------------------------------------------------------------------
package gmsb_pkg;

    // default grid size
    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_COLS = 32;

    // field widths
    localparam int OP_W    = 2;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 5;
    localparam int DIST_W  = 7;
    localparam int CFG_W   = 6;
    localparam int LIM_W   = 9;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int S_DW    = 16;
    localparam int M_DW    = 8;

    localparam int NUM_DIRS = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    localparam logic signed [DIST_W-1:0] DIST_MAX       = 7'sd63;
    localparam logic signed [DIST_W-1:0] DIST_UNREACHED = -7'sd1;
    localparam logic signed [DIST_W-1:0] DIST_ONE       = 7'sd1;

    // register select bit of paddr
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_RUN   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_POP,
        ST_FETCH,
        ST_DIST,
        ST_CHAIN,
        ST_HOLD
    } state_t;

    // requests of one neighbor cell toward the grid and queue
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic busy;
    } cell_flags_t;

    // coordinate width, at least one bit
    function automatic int coord_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // width of a {row, col} cell address
    function automatic int addr_w(input int rows, input int cols);
        return coord_w(rows) + coord_w(cols);
    endfunction

endpackage
`default_nettype wire

@@ src/gmsb_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gmsb_cell
// One neighbor cell of the expansion chain: takes the popped cell from its
// left neighbor, probes one direction, then marks and enqueues an unreached
// neighbor in the cycle after the probe. The token moves on to the next cell every cycle.
// ----------------------------------------------------------------------------
module gmsb_cell #(
    parameter int             MAX_ROWS = gmsb_pkg::DEF_MAX_ROWS,
    parameter int             MAX_COLS = gmsb_pkg::DEF_MAX_COLS,
    parameter gmsb_pkg::dir_t DIR      = gmsb_pkg::DIR_UP
) (
    input  wire logic                                                 aclk,
    input  wire logic                                                 aresetn,
    input  wire logic                                                 in_valid,
    input  wire logic [gmsb_pkg::addr_w(MAX_ROWS, MAX_COLS)-1:0]      in_addr,
    input  wire logic signed [gmsb_pkg::DIST_W-1:0]                   in_dist,
    input  wire logic [gmsb_pkg::LIM_W-1:0]                           row_lim,
    input  wire logic [gmsb_pkg::LIM_W-1:0]                           col_lim,
    input  wire logic signed [gmsb_pkg::DIST_W-1:0]                   rd_data,
    output logic                                                      out_valid,
    output logic [gmsb_pkg::addr_w(MAX_ROWS, MAX_COLS)-1:0]           out_addr,
    output logic signed [gmsb_pkg::DIST_W-1:0]                        out_dist,
    output gmsb_pkg::cell_flags_t                                     flags,
    output logic [gmsb_pkg::addr_w(MAX_ROWS, MAX_COLS)-1:0]           rd_addr,
    output logic [gmsb_pkg::addr_w(MAX_ROWS, MAX_COLS)-1:0]           wr_addr,
    output logic signed [gmsb_pkg::DIST_W-1:0]                        wr_data
);
    import gmsb_pkg::*;

    localparam int RW = coord_w(MAX_ROWS);
    localparam int CW = coord_w(MAX_COLS);
    localparam int AW = RW + CW;

    logic                     tok_vld_reg;
    logic [AW-1:0]            tok_addr_reg;
    logic signed [DIST_W-1:0] tok_dist_reg;
    logic                     chk_vld_reg;
    logic                     chk_vld_next;
    logic [AW-1:0]            chk_addr_reg;
    logic signed [DIST_W-1:0] chk_dist_reg;

    logic [RW-1:0] tok_row;
    logic [CW-1:0] tok_col;
    logic [RW-1:0] nbr_row;
    logic [CW-1:0] nbr_col;
    logic          nbr_in;

    assign tok_row = tok_addr_reg[AW-1:CW];
    assign tok_col = tok_addr_reg[CW-1:0];

    // neighbor coordinate and bounds test for this direction
    // the popped cell itself may lie outside limits written after it was queued
    always_comb begin
        nbr_row = tok_row;
        nbr_col = tok_col;
        nbr_in  = 1'b0;
        case (DIR)
            DIR_UP: begin
                nbr_row = tok_row - RW'(1);
                nbr_in  = (tok_row != '0) && (LIM_W'(tok_row) <= row_lim) &&
                          (LIM_W'(tok_col) < col_lim);
            end
            DIR_DOWN: begin
                nbr_row = tok_row + RW'(1);
                nbr_in  = ((LIM_W'(tok_row) + LIM_W'(1)) < row_lim) &&
                          (LIM_W'(tok_col) < col_lim);
            end
            DIR_LEFT: begin
                nbr_col = tok_col - CW'(1);
                nbr_in  = (tok_col != '0) && (LIM_W'(tok_col) <= col_lim) &&
                          (LIM_W'(tok_row) < row_lim);
            end
            DIR_RIGHT: begin
                nbr_col = tok_col + CW'(1);
                nbr_in  = ((LIM_W'(tok_col) + LIM_W'(1)) < col_lim) &&
                          (LIM_W'(tok_row) < row_lim);
            end
            default: begin
                nbr_in = 1'b0;
            end
        endcase
    end

    assign chk_vld_next = tok_vld_reg & nbr_in;

    // probe now, mark on the next cycle when the neighbor is still unreached
    assign flags.rd_en = chk_vld_next;
    assign flags.wr_en = chk_vld_reg && (rd_data == DIST_UNREACHED);
    assign flags.busy  = tok_vld_reg | chk_vld_reg;
    assign rd_addr     = {nbr_row, nbr_col};
    assign wr_addr     = chk_addr_reg;
    assign wr_data     = chk_dist_reg;

    assign out_valid = tok_vld_reg;
    assign out_addr  = tok_addr_reg;
    assign out_dist  = tok_dist_reg;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_vld_reg <= 1'b0;
            chk_vld_reg <= 1'b0;
        end else begin
            tok_vld_reg <= in_valid;
            chk_vld_reg <= chk_vld_next;
        end
    end

    // token and probe payload
    always_ff @(posedge aclk) begin
        tok_addr_reg <= in_addr;
        tok_dist_reg <= in_dist;
        chk_addr_reg <= {nbr_row, nbr_col};
        chk_dist_reg <= tok_dist_reg;
    end

endmodule
`default_nettype wire

@@ src/grid_multi_source_bfs_distance.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// grid_multi_source_bfs_distance: multi-source 4-neighbor distance flood
// Add writes the grid and queue; read answers after a registered grid read; clear
// sweeps the grid. Run pops each queued cell (queue read, grid read, 4-cell chain).
// One item at a time; a result that meets a stall waits in the hold register.
// Reset sweeps the grid to unreached, no items taken.
// ----------------------------------------------------------------------------
module grid_multi_source_bfs_distance #(
    parameter int MAX_ROWS = gmsb_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gmsb_pkg::DEF_MAX_COLS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // command items
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [1:0] operation, [6:2] row, [11:7] col, [15:12] zero
    input  wire logic [gmsb_pkg::S_DW-1:0]     s_tdata,
    // result items
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [6:0] distance (signed), [7] coord_ok
    output logic [gmsb_pkg::M_DW-1:0]          m_tdata,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gmsb_pkg::APB_AW-1:0]   paddr,
    input  wire logic [gmsb_pkg::APB_DW-1:0]   pwdata,
    output logic [gmsb_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);
    import gmsb_pkg::*;

    localparam int RW     = coord_w(MAX_ROWS);
    localparam int CW     = coord_w(MAX_COLS);
    localparam int GAW    = RW + CW;
    localparam int GDEPTH = MAX_ROWS * (2 ** CW);
    localparam int QDEPTH = MAX_ROWS * MAX_COLS;
    localparam int QAW    = coord_w(QDEPTH);

    // configuration registers
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    logic             cfg_wr;
    logic [LIM_W-1:0] rows_lim;
    logic [LIM_W-1:0] cols_lim;

    // command fields
    op_t              s_op;
    logic [ROW_W-1:0] s_row;
    logic [COL_W-1:0] s_col;
    logic             s_ok;
    logic [GAW-1:0]   s_addr;
    logic             s_acc;
    logic             cmd_ok_reg;

    // control
    state_t           state_reg;
    state_t           state_next;
    logic [GAW-1:0]   sweep_cnt_reg;
    logic [GAW-1:0]   sweep_cnt_next;
    logic             sweep_last;

    // grid memory
    logic signed [DIST_W-1:0] grid_mem [GDEPTH];
    logic signed [DIST_W-1:0] grid_rdata_reg;
    logic                     g_re;
    logic [GAW-1:0]           g_raddr;
    logic                     g_we;
    logic [GAW-1:0]           g_waddr;
    logic signed [DIST_W-1:0] g_wdata;

    // cell queue
    logic [GAW-1:0] q_mem [QDEPTH];
    logic [GAW-1:0] q_rdata_reg;
    logic [QAW-1:0] head_reg;
    logic [QAW-1:0] head_next;
    logic [QAW-1:0] tail_reg;
    logic [QAW-1:0] tail_next;
    logic           head_ph_reg;
    logic           head_ph_next;
    logic           tail_ph_reg;
    logic           tail_ph_next;
    logic           q_empty;
    logic           q_full;
    logic           q_re;
    logic           q_push;
    logic           q_push_eff;
    logic           q_clr;
    logic [GAW-1:0] q_wdata;

    // neighbor chain
    logic                     lnk_vld  [NUM_DIRS];
    logic [GAW-1:0]           lnk_addr [NUM_DIRS];
    logic signed [DIST_W-1:0] lnk_dist [NUM_DIRS];
    cell_flags_t              c_flags  [NUM_DIRS];
    logic [GAW-1:0]           c_raddr  [NUM_DIRS];
    logic [GAW-1:0]           c_waddr  [NUM_DIRS];
    logic signed [DIST_W-1:0] c_wdata  [NUM_DIRS];
    logic                     cell_rd;
    logic [GAW-1:0]           cell_raddr;
    logic                     cell_we;
    logic [GAW-1:0]           cell_waddr;
    logic signed [DIST_W-1:0] cell_wdata;
    logic                     chain_busy;
    logic signed [DIST_W-1:0] inj_dist;
    logic                     inj_vld;

    // results
    logic                     fin_vld;
    logic signed [DIST_W-1:0] fin_dist;
    logic                     fin_ok;
    logic                     out_free;
    logic                     load_out;
    logic signed [DIST_W-1:0] res_dist_reg;
    logic                     res_ok_reg;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic signed [DIST_W-1:0] m_dist_reg;
    logic                     m_ok_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_COLS) ? APB_DW'(cols_reg) : APB_DW'(rows_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= CFG_RESET;
            cols_reg <= CFG_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_ROWS) begin
                rows_reg <= pwdata[CFG_W-1:0];
            end else begin
                cols_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    // effective bounds, capped at the grid size
    assign rows_lim = (LIM_W'(rows_reg) > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS)
                                                             : LIM_W'(rows_reg);
    assign cols_lim = (LIM_W'(cols_reg) > LIM_W'(MAX_COLS)) ? LIM_W'(MAX_COLS)
                                                             : LIM_W'(cols_reg);

    // command decode
    assign s_op   = op_t'(s_tdata[OP_W-1:0]);
    assign s_row  = s_tdata[OP_W+ROW_W-1:OP_W];
    assign s_col  = s_tdata[OP_W+ROW_W+COL_W-1:OP_W+ROW_W];
    assign s_ok   = (LIM_W'(s_row) < rows_lim) && (LIM_W'(s_col) < cols_lim);
    assign s_addr = {RW'(s_row), CW'(s_col)};
    assign s_acc  = s_tvalid & s_tready;

    // queue status
    assign q_empty    = (head_reg == tail_reg) && (head_ph_reg == tail_ph_reg);
    assign q_full     = (head_reg == tail_reg) && (head_ph_reg != tail_ph_reg);
    assign q_push_eff = q_push & ~q_full;

    assign sweep_last = (sweep_cnt_reg == GAW'(GDEPTH - 1));

    // distance handed to the neighbors, saturating
    assign inj_dist = (grid_rdata_reg < DIST_MAX) ? grid_rdata_reg + DIST_ONE : DIST_MAX;

    // neighbor cells, one per direction
    assign lnk_vld[0]  = inj_vld;
    assign lnk_addr[0] = q_rdata_reg;
    assign lnk_dist[0] = inj_dist;

    for (genvar k = 0; k < NUM_DIRS; k++) begin : g_cell
        if (k < NUM_DIRS - 1) begin : g_mid
            gmsb_cell #(
                .MAX_ROWS (MAX_ROWS),
                .MAX_COLS (MAX_COLS),
                .DIR      (dir_t'(k))
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (lnk_vld[k]),
                .in_addr   (lnk_addr[k]),
                .in_dist   (lnk_dist[k]),
                .row_lim   (rows_lim),
                .col_lim   (cols_lim),
                .rd_data   (grid_rdata_reg),
                .out_valid (lnk_vld[k+1]),
                .out_addr  (lnk_addr[k+1]),
                .out_dist  (lnk_dist[k+1]),
                .flags     (c_flags[k]),
                .rd_addr   (c_raddr[k]),
                .wr_addr   (c_waddr[k]),
                .wr_data   (c_wdata[k])
            );
        end else begin : g_last
            gmsb_cell #(
                .MAX_ROWS (MAX_ROWS),
                .MAX_COLS (MAX_COLS),
                .DIR      (dir_t'(k))
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (lnk_vld[k]),
                .in_addr   (lnk_addr[k]),
                .in_dist   (lnk_dist[k]),
                .row_lim   (rows_lim),
                .col_lim   (cols_lim),
                .rd_data   (grid_rdata_reg),
                .out_valid (),
                .out_addr  (),
                .out_dist  (),
                .flags     (c_flags[k]),
                .rd_addr   (c_raddr[k]),
                .wr_addr   (c_waddr[k]),
                .wr_data   (c_wdata[k])
            );
        end
    end

    // merge cell requests, at most one reader and one writer at a time
    always_comb begin
        cell_rd    = 1'b0;
        cell_raddr = '0;
        cell_we    = 1'b0;
        cell_waddr = '0;
        cell_wdata = '0;
        chain_busy = 1'b0;
        for (int k = 0; k < NUM_DIRS; k++) begin
            if (c_flags[k].rd_en) begin
                cell_rd    = 1'b1;
                cell_raddr = c_raddr[k];
            end
            if (c_flags[k].wr_en) begin
                cell_we    = 1'b1;
                cell_waddr = c_waddr[k];
                cell_wdata = c_wdata[k];
            end
            chain_busy = chain_busy | c_flags[k].busy;
        end
    end

    assign out_free = ~m_valid_reg | m_tready;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        s_tready       = 1'b0;
        g_re           = 1'b0;
        g_raddr        = cell_raddr;
        g_we           = 1'b0;
        g_waddr        = cell_waddr;
        g_wdata        = cell_wdata;
        q_re           = 1'b0;
        q_push         = 1'b0;
        q_wdata        = cell_waddr;
        q_clr          = 1'b0;
        inj_vld        = 1'b0;
        fin_vld        = 1'b0;
        fin_dist       = '0;
        fin_ok         = 1'b0;
        case (state_reg)
            ST_INIT: begin
                g_we           = 1'b1;
                g_waddr        = sweep_cnt_reg;
                g_wdata        = DIST_UNREACHED;
                sweep_cnt_next = sweep_cnt_reg + GAW'(1);
                if (sweep_last) begin
                    sweep_cnt_next = '0;
                    state_next     = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (s_op)
                        OP_CLEAR: begin
                            q_clr          = 1'b1;
                            sweep_cnt_next = '0;
                            state_next     = ST_CLEAR;
                        end
                        OP_ADD: begin
                            g_we    = s_ok;
                            g_waddr = s_addr;
                            g_wdata = '0;
                            q_push  = s_ok;
                            q_wdata = s_addr;
                            fin_vld = 1'b1;
                            fin_ok  = s_ok;
                        end
                        OP_RUN: begin
                            state_next = ST_POP;
                        end
                        OP_READ: begin
                            g_re       = s_ok;
                            g_raddr    = s_addr;
                            state_next = ST_READ;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                g_we           = 1'b1;
                g_waddr        = sweep_cnt_reg;
                g_wdata        = DIST_UNREACHED;
                sweep_cnt_next = sweep_cnt_reg + GAW'(1);
                if (sweep_last) begin
                    sweep_cnt_next = '0;
                    fin_vld        = 1'b1;
                end
            end
            ST_READ: begin
                fin_vld  = 1'b1;
                fin_ok   = cmd_ok_reg;
                fin_dist = cmd_ok_reg ? grid_rdata_reg : '0;
            end
            ST_POP: begin
                if (q_empty) begin
                    fin_vld = 1'b1;
                end else begin
                    q_re       = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                g_re       = 1'b1;
                g_raddr    = q_rdata_reg;
                state_next = ST_DIST;
            end
            ST_DIST: begin
                inj_vld    = 1'b1;
                state_next = ST_CHAIN;
            end
            ST_CHAIN: begin
                g_re   = cell_rd;
                g_we   = cell_we;
                q_push = cell_we;
                if (!chain_busy) begin
                    state_next = ST_POP;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // a finished result either goes out or waits in the hold register
        if (fin_vld) begin
            state_next = out_free ? ST_IDLE : ST_HOLD;
        end
    end

    // queue pointers, wrapping at the queue depth with a phase bit
    always_comb begin
        head_next    = head_reg;
        head_ph_next = head_ph_reg;
        tail_next    = tail_reg;
        tail_ph_next = tail_ph_reg;
        if (q_clr) begin
            head_next    = '0;
            head_ph_next = 1'b0;
            tail_next    = '0;
            tail_ph_next = 1'b0;
        end else begin
            if (q_re) begin
                if (head_reg == QAW'(QDEPTH - 1)) begin
                    head_next    = '0;
                    head_ph_next = ~head_ph_reg;
                end else begin
                    head_next = head_reg + QAW'(1);
                end
            end
            if (q_push_eff) begin
                if (tail_reg == QAW'(QDEPTH - 1)) begin
                    tail_next    = '0;
                    tail_ph_next = ~tail_ph_reg;
                end else begin
                    tail_next = tail_reg + QAW'(1);
                end
            end
        end
    end

    // output register
    assign load_out     = out_free & (fin_vld | (state_reg == ST_HOLD));
    assign m_valid_next = load_out ? 1'b1 : (m_valid_reg & ~m_tready);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            sweep_cnt_reg <= '0;
            head_reg      <= '0;
            head_ph_reg   <= 1'b0;
            tail_reg      <= '0;
            tail_ph_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            head_reg      <= head_next;
            head_ph_reg   <= head_ph_next;
            tail_reg      <= tail_next;
            tail_ph_reg   <= tail_ph_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cmd_ok_reg <= s_ok;
        end
        if (fin_vld && !out_free) begin
            res_dist_reg <= fin_dist;
            res_ok_reg   <= fin_ok;
        end
        if (load_out) begin
            if (fin_vld) begin
                m_dist_reg <= fin_dist;
                m_ok_reg   <= fin_ok;
            end else begin
                m_dist_reg <= res_dist_reg;
                m_ok_reg   <= res_ok_reg;
            end
        end
    end

    // grid memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (g_we) begin
            grid_mem[g_waddr] <= g_wdata;
        end
        if (g_re) begin
            grid_rdata_reg <= grid_mem[g_raddr];
        end
    end

    // queue memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (q_push_eff) begin
            q_mem[tail_reg] <= q_wdata;
        end
        if (q_re) begin
            q_rdata_reg <= q_mem[head_reg];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_ok_reg, m_dist_reg};

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: testbench of the grid breadth-first distance block
// Sends clear, add, run and read commands over the input stream and programs
// the row and column limits over the APB port between phases. An in-bench
// flood model predicts each command's result, and every result item is
// compared field by field against it. The sender works in bursts and the
// receiver stalls, with one long hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb_top;
    import gmsb_pkg::*;

    localparam int CELLS        = DEF_MAX_ROWS * DEF_MAX_COLS;
    localparam int IDX_W        = $clog2(CELLS);
    localparam int ITEM_TARGET  = 1600;
    localparam int FILL_ADDS    = CELLS + 6;
    localparam int IDLE_GUARD   = 16;
    localparam int LONG_HOLD    = 600;
    localparam int CYCLE_LIMIT  = 3_000_000;

    localparam logic [APB_AW-1:0] ADDR_ROWS = {REG_ROWS, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_COLS = {REG_COLS, 2'b00};

    // command item, op in the lowest bits as on s_tdata
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        op_t              op;
    } grid_cmd_t;

    // result item, distance in the lowest bits as on m_tdata
    typedef struct packed {
        logic                     coord_ok;
        logic signed [DIST_W-1:0] distance;
    } cell_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // [1:0] operation, [6:2] row, [11:7] col, [15:12] zero
    logic [S_DW-1:0]   s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // [6:0] distance (signed), [7] coord_ok
    logic [M_DW-1:0]   m_tdata;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    grid_multi_source_bfs_distance dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // flood model state
    logic signed [DIST_W-1:0] dist_map [CELLS];
    logic [IDX_W-1:0]         flood_fifo [CELLS];
    logic [IDX_W:0]           fifo_rd;
    logic [IDX_W:0]           fifo_wr;
    logic [CFG_W-1:0]         rows_cfg;
    logic [CFG_W-1:0]         cols_cfg;

    // bench bookkeeping
    grid_cmd_t    cmd_pending[$];
    cell_result_t dist_expected[$];
    int           n_queued     = 0;
    int           n_accepted   = 0;
    int           n_results    = 0;
    int           n_effective  = 0;
    int           n_settings   = 0;
    int           err_count    = 0;
    int           op_seen [4]  = '{0, 0, 0, 0};
    logic [31:0]  cycle_cnt    = '0;
    int           burst_left   = 0;
    int           gap_left     = 0;
    int           hold_left    = 0;
    bit           long_hold_req  = 1'b0;
    bit           long_hold_done = 1'b0;

    // limits above the grid size act as the grid size
    function automatic int eff_limit(logic [CFG_W-1:0] v, int maxv);
        return (int'(v) > maxv) ? maxv : int'(v);
    endfunction

    function automatic void flood_clear();
        for (int i = 0; i < CELLS; i++) dist_map[i] = DIST_UNREACHED;
        fifo_rd = '0;
        fifo_wr = '0;
    endfunction

    // a full queue drops the push
    function automatic void flood_push(int idx);
        logic [IDX_W:0] used;
        used = fifo_wr - fifo_rd;
        if (used != CELLS) begin
            flood_fifo[fifo_wr[IDX_W-1:0]] = idx[IDX_W-1:0];
            fifo_wr = fifo_wr + 1'b1;
        end
    endfunction

    // pop until empty, each unreached neighbor in bounds gets parent + 1
    function automatic void flood_run();
        int nr, nc, r, c, rr, cc, ni;
        logic [IDX_W-1:0] cur_idx;
        logic signed [DIST_W-1:0] step_dist;
        nr = eff_limit(rows_cfg, DEF_MAX_ROWS);
        nc = eff_limit(cols_cfg, DEF_MAX_COLS);
        while (fifo_wr != fifo_rd) begin
            cur_idx = flood_fifo[fifo_rd[IDX_W-1:0]];
            fifo_rd = fifo_rd + 1'b1;
            r = int'(cur_idx) / DEF_MAX_COLS;
            c = int'(cur_idx) % DEF_MAX_COLS;
            step_dist = dist_map[cur_idx];
            if (step_dist < DIST_MAX) step_dist = step_dist + DIST_ONE;
            for (int k = 0; k < NUM_DIRS; k++) begin
                rr = r;
                cc = c;
                case (dir_t'(k))
                    DIR_UP:    rr = r - 1;
                    DIR_DOWN:  rr = r + 1;
                    DIR_LEFT:  cc = c - 1;
                    DIR_RIGHT: cc = c + 1;
                    default:   rr = r;
                endcase
                if (rr >= 0 && rr < nr && cc >= 0 && cc < nc) begin
                    ni = rr * DEF_MAX_COLS + cc;
                    if (dist_map[ni] == DIST_UNREACHED) begin
                        dist_map[ni] = step_dist;
                        flood_push(ni);
                    end
                end
            end
        end
    endfunction

    // result of one command, updating the model state
    function automatic cell_result_t apply_command(grid_cmd_t cmd);
        cell_result_t res;
        int idx;
        logic ok;
        res = '0;
        idx = int'(cmd.row) * DEF_MAX_COLS + int'(cmd.col);
        ok = (int'(cmd.row) < eff_limit(rows_cfg, DEF_MAX_ROWS)) &&
             (int'(cmd.col) < eff_limit(cols_cfg, DEF_MAX_COLS));
        case (cmd.op)
            OP_CLEAR: flood_clear();
            OP_ADD: begin
                if (ok) begin
                    dist_map[idx] = '0;
                    flood_push(idx);
                    res.coord_ok = 1'b1;
                end
            end
            OP_RUN:   flood_run();
            OP_READ: begin
                if (ok) begin
                    res.distance = dist_map[idx];
                    res.coord_ok = 1'b1;
                end
            end
            default: res = '0;
        endcase
        return res;
    endfunction

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // command driver: bursts of random length with random gaps
    always @(posedge aclk) begin
        grid_cmd_t next_cmd;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (cmd_pending.size() != 0) begin
                next_cmd = cmd_pending.pop_front();
                s_tdata  <= {{(S_DW - $bits(grid_cmd_t)){1'b0}}, next_cmd};
                s_tvalid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(0, 30);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: stall pattern set by cycle_cnt[8:7], one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            hold_left      <= LONG_HOLD;
            long_hold_done <= 1'b1;
            m_tready       <= 1'b0;
        end else begin
            case (cycle_cnt[8:7])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= ($urandom_range(0, 1) == 0);
                2'd2: m_tready <= ($urandom_range(0, 3) == 0);
                2'd3: m_tready <= cycle_cnt[2];
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // monitor: predict on accepted commands, check accepted results
    always @(posedge aclk) begin
        grid_cmd_t    cmd;
        cell_result_t got;
        cell_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                cmd = s_tdata[$bits(grid_cmd_t)-1:0];
                dist_expected.insert(dist_expected.size(), apply_command(cmd));
                op_seen[cmd.op]++;
                n_accepted++;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (dist_expected.size() == 0) begin
                    $error("unexpected result item %h", m_tdata);
                    err_count++;
                end else begin
                    want = dist_expected.pop_front();
                    n_results++;
                    if (got.distance !== want.distance) begin
                        $error("distance: expected %0d, got %0d", want.distance, got.distance);
                        err_count++;
                    end
                    if (got.coord_ok !== want.coord_ok) begin
                        $error("coord_ok: expected %0d, got %0d", want.coord_ok, got.coord_ok);
                        err_count++;
                    end
                end
            end
        end
    end

    task automatic push_cmd(op_t op, int r, int c);
        grid_cmd_t cmd;
        cmd.op  = op;
        cmd.row = r[ROW_W-1:0];
        cmd.col = c[COL_W-1:0];
        cmd_pending.insert(cmd_pending.size(), cmd);
        n_queued++;
        // out-of-grid adds and reads answer with coord_ok low and leave the grid as is
        if (op == OP_CLEAR || op == OP_RUN ||
            (r < eff_limit(rows_cfg, DEF_MAX_ROWS) && c < eff_limit(cols_cfg, DEF_MAX_COLS)))
            n_effective++;
    endtask

    // coordinate inside the active grid, or anywhere in the field
    function automatic int pick_coord(int lim, bit in_grid);
        if (in_grid && lim > 0) return $urandom_range(0, lim - 1);
        if (lim < 32 && $urandom_range(0, 1) == 1) return $urandom_range(lim, 31);
        return $urandom_range(0, 31);
    endfunction

    // wait until every command is answered and the block is idle
    task automatic settle();
        while (n_accepted != n_queued || dist_expected.size() != 0) @(posedge aclk);
        repeat (IDLE_GUARD) @(posedge aclk);
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [CFG_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= ($urandom() & ~32'h3F) | APB_DW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ROWS) rows_cfg = value;
        else cols_cfg = value;
    endtask

    task automatic set_grid(int rows, int cols);
        settle();
        apb_write(ADDR_ROWS, rows[CFG_W-1:0]);
        apb_write(ADDR_COLS, cols[CFG_W-1:0]);
        n_settings++;
    endtask

    // stimulus
    initial begin
        int nr, nc, sel, phase_len, start, pick;
        flood_clear();
        rows_cfg = CFG_RESET;
        cols_cfg = CFG_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: corners, repeated source, source on a reached cell
        push_cmd(OP_READ, 31, 31);
        push_cmd(OP_CLEAR, 31, 31);
        push_cmd(OP_ADD, 0, 0);
        push_cmd(OP_ADD, 0, 0);
        push_cmd(OP_ADD, 31, 31);
        push_cmd(OP_READ, 0, 0);
        push_cmd(OP_RUN, 0, 0);
        push_cmd(OP_READ, 31, 0);
        push_cmd(OP_READ, 0, 31);
        push_cmd(OP_READ, 21, 10);
        push_cmd(OP_READ, 10, 21);
        push_cmd(OP_ADD, 16, 16);
        push_cmd(OP_RUN, 0, 0);
        push_cmd(OP_READ, 16, 16);
        push_cmd(OP_RUN, 0, 0);
        push_cmd(OP_CLEAR, 0, 0);
        push_cmd(OP_READ, 16, 16);
        // sources queued under one setting, flooded under another
        push_cmd(OP_ADD, 2, 2);
        push_cmd(OP_ADD, 30, 30);
        set_grid(3, 3);
        push_cmd(OP_RUN, 0, 0);
        push_cmd(OP_READ, 2, 0);
        push_cmd(OP_READ, 30, 30);
        // zero rows, and limits above the grid size
        set_grid(0, 63);
        push_cmd(OP_ADD, 0, 0);
        push_cmd(OP_READ, 0, 0);
        set_grid(63, 63);
        push_cmd(OP_READ, 30, 30);
        push_cmd(OP_READ, 29, 30);
        push_cmd(OP_ADD, 31, 31);

        // more adds than the queue holds, with the receiver held off
        set_grid(32, 32);
        push_cmd(OP_CLEAR, 0, 0);
        long_hold_req = 1'b1;
        repeat (FILL_ADDS) push_cmd(OP_ADD, $urandom_range(0, 31), $urandom_range(0, 31));
        push_cmd(OP_RUN, 0, 0);
        repeat (24) push_cmd(OP_READ, $urandom_range(0, 31), $urandom_range(0, 31));

        // random phases, mostly small grids
        while (n_queued < ITEM_TARGET) begin
            sel = $urandom_range(0, 19);
            case (sel)
                0: set_grid(1, 1);
                1: set_grid(32, 32);
                2: set_grid(0, $urandom_range(1, 32));
                3: set_grid($urandom_range(1, 32), 0);
                4: set_grid(63, $urandom_range(1, 8));
                5: set_grid($urandom_range(33, 63), $urandom_range(33, 63));
                6: set_grid(1, 32);
                7: set_grid(32, 1);
                default: set_grid($urandom_range(1, 8), $urandom_range(1, 8));
            endcase
            nr = eff_limit(rows_cfg, DEF_MAX_ROWS);
            nc = eff_limit(cols_cfg, DEF_MAX_COLS);
            phase_len = $urandom_range(20, 40);
            start = n_queued;
            while (n_queued - start < phase_len) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    // well-formed flood: clear, sources, run, reads
                    if ($urandom_range(0, 4) != 0)
                        push_cmd(OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31));
                    repeat ($urandom_range(1, 4))
                        push_cmd(OP_ADD, pick_coord(nr, $urandom_range(0, 9) != 0),
                                 pick_coord(nc, $urandom_range(0, 9) != 0));
                    push_cmd(OP_RUN, $urandom_range(0, 31), $urandom_range(0, 31));
                    repeat ($urandom_range(2, 8))
                        push_cmd(OP_READ, pick_coord(nr, $urandom_range(0, 6) != 0),
                                 pick_coord(nc, $urandom_range(0, 6) != 0));
                end else if (pick < 85) begin
                    // sources that may carry over into the next setting
                    repeat ($urandom_range(1, 3))
                        push_cmd(OP_ADD, pick_coord(nr, 1'b1), pick_coord(nc, 1'b1));
                end else begin
                    repeat ($urandom_range(1, 4))
                        push_cmd(op_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                                 $urandom_range(0, 31));
                end
            end
        end

        settle();
        $display("summary: %0d commands (%0d clear, %0d add, %0d run, %0d read), %0d in grid",
                 n_accepted, op_seen[OP_CLEAR], op_seen[OP_ADD], op_seen[OP_RUN],
                 op_seen[OP_READ], n_effective);
        $display("summary: %0d results checked, %0d grid settings incl. zero and oversize",
                 n_results, n_settings);
        if (err_count == 0 && dist_expected.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
